// File: rtl/core/c2so_pkg.sv
// Package for the Cartesian-to-spherical offset unit: widths, payload types,
// configuration register codes and the CORDIC arctangent table.
// Depends on nothing; every other file of the block but c2so_stream_if uses it.
`default_nettype none

package c2so_pkg;

  localparam int unsigned PointW    = 32;
  localparam int unsigned DiffW     = 33;
  localparam int unsigned SqW       = 66;
  localparam int unsigned RootW     = 35;
  localparam int unsigned RadW      = 2 * RootW;
  localparam int unsigned RemW      = RootW + 3;
  localparam int unsigned ArgW      = 36;
  localparam int unsigned CordW     = 58;
  localparam int unsigned AngW      = 34;
  localparam int unsigned GuardBits = 20;
  localparam int unsigned RadiusW   = 33;
  localparam int unsigned AngleW    = 32;
  localparam int unsigned CfgIdxW   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegOriginX  = 2'd0,
    RegOriginY  = 2'd1,
    RegOriginZ  = 2'd2,
    RegRotation = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [PointW-1:0] point_x;
    logic signed [PointW-1:0] point_y;
    logic signed [PointW-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic [RadiusW-1:0] radius;
    logic [AngleW-1:0]  polar_angle;
    logic [AngleW-1:0]  azimuth;
  } result_t;

  // Offsets from the origin with the valid bit that travels beside them.
  typedef struct packed {
    logic                    valid;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] dz;
  } diff_t;

  // What the output stage needs besides the two angles.
  typedef struct packed {
    logic               valid;
    logic               rho_zero;
    logic               dz_neg;
    logic [RadiusW-1:0] radius;
  } tail_t;

  // atan(2^-i) in binary-angle units, rounded to nearest.
  function automatic logic [29:0] atan_f(input int unsigned i);
    logic [29:0] v;
    case (i)
      0:  v = 30'd536870912;
      1:  v = 30'd316933406;
      2:  v = 30'd167458907;
      3:  v = 30'd85004756;
      4:  v = 30'd42667331;
      5:  v = 30'd21354465;
      6:  v = 30'd10679838;
      7:  v = 30'd5340245;
      8:  v = 30'd2670163;
      9:  v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      24: v = 30'd41;
      25: v = 30'd20;
      26: v = 30'd10;
      27: v = 30'd5;
      28: v = 30'd3;
      29: v = 30'd1;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/c2so_stream_if.sv
// Valid/ready stream interface used for the point and result channels.
// Depends on nothing; the payload type is a parameter.
`default_nettype none

interface c2so_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/c2so_sqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on c2so_pkg.
`default_nettype none

module c2so_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [c2so_pkg::SqW-1:0]    rad_i,
  output logic [c2so_pkg::RootW-1:0]  root_o
);

  localparam int unsigned RootW = c2so_pkg::RootW;
  localparam int unsigned RadW  = c2so_pkg::RadW;
  localparam int unsigned RemW  = c2so_pkg::RemW;

  logic [RadW-1:0]  rad_q  [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RadW-1:0]  rad_p;
    logic [RemW-1:0]  rem_p;
    logic [RootW-1:0] root_p;
    logic [RadW-1:0]  rad_d;
    logic [RemW-1:0]  rem_d;
    logic [RootW-1:0] root_d;
    logic [RemW-1:0]  cur;
    logic [RemW-1:0]  trial;

    if (k == 0) begin : g_first
      assign rad_p  = RadW'(rad_i);
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
      cur   = {rem_p[RemW-3:0], rad_p[RadW-1 -: 2]};
      trial = RemW'({root_p, 2'b01});
      rad_d = rad_p << 2;
      if (cur >= trial) begin
        rem_d  = cur - trial;
        root_d = {root_p[RootW-2:0], 1'b1};
      end else begin
        rem_d  = cur;
        root_d = {root_p[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_d;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

`default_nettype wire

// File: rtl/core/c2so_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) as a binary angle.
// One quadrant pre-rotation stage, then one register stage per iteration.
// Depends on c2so_pkg.
`default_nettype none

module c2so_cordic #(
  parameter int unsigned Stages = 32
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [c2so_pkg::ArgW-1:0]  x_i,
  input  logic signed [c2so_pkg::ArgW-1:0]  y_i,
  output logic signed [c2so_pkg::AngW-1:0]  ang_o
);

  localparam int unsigned CordW = c2so_pkg::CordW;
  localparam int unsigned AngW  = c2so_pkg::AngW;
  localparam int unsigned ArgW  = c2so_pkg::ArgW;

  logic signed [CordW-1:0] x_q [Stages+1];
  logic signed [CordW-1:0] y_q [Stages+1];
  logic signed [AngW-1:0]  a_q [Stages+1];

  logic signed [ArgW-1:0]  x0;
  logic signed [ArgW-1:0]  y0;
  logic signed [AngW-1:0]  a0;

  // Vectors in the left half plane are turned by a quarter turn first.
  always_comb begin
    x0 = x_i;
    y0 = y_i;
    a0 = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0 = y_i;
        y0 = -x_i;
        a0 = AngW'(34'sd1073741824);
      end else begin
        x0 = -y_i;
        y0 = x_i;
        a0 = -AngW'(34'sd1073741824);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CordW'(x0) <<< c2so_pkg::GuardBits;
      y_q[0] <= CordW'(y0) <<< c2so_pkg::GuardBits;
      a_q[0] <= a0;
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_iter
    logic signed [CordW-1:0] xs;
    logic signed [CordW-1:0] ys;
    logic signed [AngW-1:0]  step;

    assign xs   = x_q[i] >>> i;
    assign ys   = y_q[i] >>> i;
    assign step = AngW'(c2so_pkg::atan_f(i));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          a_q[i+1] <= a_q[i] + step;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          a_q[i+1] <= a_q[i] - step;
        end
      end
    end
  end

  assign ang_o = a_q[Stages];

endmodule

`default_nettype wire

// File: rtl/core/cartesian_to_spherical_offset_unit.sv
// Converts absolute Cartesian points (signed Q16.16) into radius, polar angle
// and azimuth relative to a configured origin and rotation. It takes one point
// per cycle when the output is not stalled. Each point passes through the
// offset register, the squares and the sums of squares, the bit-per-stage
// square roots, the arctangent pipelines and the output register. A stall at
// the output holds the whole pipeline. Configuration writes take effect at
// once and are meant to be made while no point is in flight.
// Depends on c2so_pkg, c2so_stream_if, c2so_sqrt and c2so_cordic.
`default_nettype none

module cartesian_to_spherical_offset_unit #(
  parameter int unsigned CORDIC_STAGES = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [c2so_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [c2so_pkg::PointW-1:0]     cfg_data_i,
  c2so_stream_if.sink                     pt_i,
  c2so_stream_if.source                   res_o
);

  localparam int unsigned RootW = c2so_pkg::RootW;
  localparam int unsigned DiffW = c2so_pkg::DiffW;
  localparam int unsigned ArgW  = c2so_pkg::ArgW;
  localparam int unsigned AngW  = c2so_pkg::AngW;
  localparam int unsigned SqW   = c2so_pkg::SqW;
  localparam int unsigned CordLat = CORDIC_STAGES + 1;

  logic signed [31:0] org_x_q, org_y_q, org_z_q, rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      rot_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (c2so_pkg::cfg_reg_e'(cfg_idx_i))
        c2so_pkg::RegOriginX:  org_x_q <= cfg_data_i;
        c2so_pkg::RegOriginY:  org_y_q <= cfg_data_i;
        c2so_pkg::RegOriginZ:  org_z_q <= cfg_data_i;
        c2so_pkg::RegRotation: rot_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic res_valid_q;
  c2so_pkg::result_t res_q;

  assign en         = !res_valid_q || res_o.ready;
  assign pt_i.ready = en;

  // Offset from the origin.
  c2so_pkg::diff_t d1_q, d2_q, d3_q;
  c2so_pkg::point_t pt;
  assign pt = pt_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
    end else if (en) begin
      d1_q.valid <= pt_i.valid;
      d1_q.dx    <= {pt.point_x[31], pt.point_x} - {org_x_q[31], org_x_q};
      d1_q.dy    <= {pt.point_y[31], pt.point_y} - {org_y_q[31], org_y_q};
      d1_q.dz    <= {pt.point_z[31], pt.point_z} - {org_z_q[31], org_z_q};
    end
  end

  // Squares of the magnitudes.
  logic [DiffW-1:0] ax, ay, az;
  logic [SqW-1:0]   sqx_q, sqy_q, sqz_q;
  logic [SqW-1:0]   s2_q, s3_q;

  assign ax = d1_q.dx[DiffW-1] ? DiffW'(-d1_q.dx) : DiffW'(d1_q.dx);
  assign ay = d1_q.dy[DiffW-1] ? DiffW'(-d1_q.dy) : DiffW'(d1_q.dy);
  assign az = d1_q.dz[DiffW-1] ? DiffW'(-d1_q.dz) : DiffW'(d1_q.dz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d2_q <= '0;
      d3_q <= '0;
    end else if (en) begin
      d2_q <= d1_q;
      d3_q <= d2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= {{DiffW{1'b0}}, ax} * {{DiffW{1'b0}}, ax};
      sqy_q <= {{DiffW{1'b0}}, ay} * {{DiffW{1'b0}}, ay};
      sqz_q <= {{DiffW{1'b0}}, az} * {{DiffW{1'b0}}, az};
      s2_q  <= sqx_q + sqy_q;
      s3_q  <= sqx_q + sqy_q + sqz_q;
    end
  end

  // Square roots; the offsets travel alongside.
  logic [RootW-1:0] rho, rad;
  c2so_pkg::diff_t  sq_side_q [RootW];

  c2so_sqrt u_sqrt_rho (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s2_q),
    .root_o (rho)
  );

  c2so_sqrt u_sqrt_rad (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s3_q),
    .root_o (rad)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RootW; k++) sq_side_q[k] <= '0;
    end else if (en) begin
      sq_side_q[0] <= d3_q;
      for (int k = 1; k < RootW; k++) sq_side_q[k] <= sq_side_q[k-1];
    end
  end

  // Arctangents.
  c2so_pkg::diff_t  sd;
  logic signed [AngW-1:0] theta_ang, phi_ang;
  c2so_pkg::tail_t  tail_d;
  c2so_pkg::tail_t  tail_q [CordLat];

  assign sd = sq_side_q[RootW-1];

  c2so_cordic #(
    .Stages (CORDIC_STAGES)
  ) u_cordic_theta (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (ArgW'(sd.dz)),
    .y_i   (signed'({1'b0, rho})),
    .ang_o (theta_ang)
  );

  c2so_cordic #(
    .Stages (CORDIC_STAGES)
  ) u_cordic_phi (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (ArgW'(sd.dx)),
    .y_i   (ArgW'(sd.dy)),
    .ang_o (phi_ang)
  );

  always_comb begin
    tail_d.valid    = sd.valid;
    tail_d.rho_zero = (rho == '0);
    tail_d.dz_neg   = sd.dz[DiffW-1];
    tail_d.radius   = rad[c2so_pkg::RadiusW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CordLat; k++) tail_q[k] <= '0;
    end else if (en) begin
      tail_q[0] <= tail_d;
      for (int k = 1; k < CordLat; k++) tail_q[k] <= tail_q[k-1];
    end
  end

  // Clamping, the on-axis case and the rotation.
  c2so_pkg::tail_t   tl;
  c2so_pkg::result_t res_d;
  localparam logic signed [AngW-1:0] HalfTurn = AngW'(34'sd2147483648);

  assign tl = tail_q[CordLat-1];

  always_comb begin
    res_d.radius = tl.radius;
    if (tl.rho_zero) begin
      res_d.polar_angle = tl.dz_neg ? 32'h8000_0000 : 32'h0;
      res_d.azimuth     = 32'h0 - rot_q;
    end else begin
      if (theta_ang < 0) begin
        res_d.polar_angle = 32'h0;
      end else if (theta_ang > HalfTurn) begin
        res_d.polar_angle = 32'h8000_0000;
      end else begin
        res_d.polar_angle = theta_ang[31:0];
      end
      res_d.azimuth = phi_ang[31:0] - rot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en) begin
      res_valid_q <= tl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

endmodule

`default_nettype wire

// File: rtl/core/c2so_checker.sv
// Port-level checks for the Cartesian-to-spherical offset unit, bound to it.
// Depends on c2so_pkg and cartesian_to_spherical_offset_unit.
`default_nettype none

module c2so_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input c2so_pkg::result_t out_data_i
);

  // A pending result request stays up until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  // With the output register empty the pipeline must move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // The polar angle never exceeds half a turn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.polar_angle <= 32'h8000_0000)
    else $error("polar angle beyond half a turn");

endmodule

bind cartesian_to_spherical_offset_unit c2so_checker u_c2so_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pt_i.valid),
  .in_ready_i  (pt_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_data_i  (res_o.data)
);

`default_nettype wire
